// ----- rtl/core/lab_pkg.sv -----
// ----------------------------------------------------------------------------
// lab_pkg: shared constants and helpers for the look-at basis core
// Holds register indexes, pipeline depths and the fixed-point helpers used
// by both the top level and the normalize unit.
// ----------------------------------------------------------------------------
package lab_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_EPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_EPS  = 1'd1;

  localparam int IN_EPS_W   = 16;
  localparam int UNIT_EPS_W = 21;
  localparam logic [UNIT_EPS_W-1:0] UNIT_EPS_RST = 21'd128;

  // Normalize unit depth: front end, root digits, divider setup, divider
  // digits, sign stage
  localparam int SQRT_STG = 32;
  localparam int DIV_STG  = 31;
  localparam int NORM_LAT = 5 + SQRT_STG + 1 + DIV_STG + 1;

  // Width of vectors entering the normalize unit
  localparam int VEC_W = 42;

  // Round x / 2^30 to nearest, halves away from zero
  function automatic logic signed [35:0] rnd30_fn(input logic signed [65:0] x);
    logic [65:0] m;
    logic [65:0] r;
    m = x[65] ? 66'(-x) : 66'(x);
    r = (m + (66'd1 << 29)) >> 30;
    return x[65] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  // Magnitude of a signed vector component
  function automatic logic [VEC_W-1:0] mag_fn(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
  endfunction

  // Degenerate when every component and the squared length stay within eps
  function automatic logic deg_fn(input logic signed [VEC_W-1:0] a,
                                  input logic signed [VEC_W-1:0] b,
                                  input logic signed [VEC_W-1:0] c,
                                  input logic [UNIT_EPS_W-1:0] eps);
    logic [VEC_W-1:0] ma;
    logic [VEC_W-1:0] mb;
    logic [VEC_W-1:0] mc;
    logic             near;
    logic [43:0]      s;
    logic [43:0]      e2;
    ma = mag_fn(a);
    mb = mag_fn(b);
    mc = mag_fn(c);
    near = (ma <= VEC_W'(eps)) && (mb <= VEC_W'(eps)) && (mc <= VEC_W'(eps));
    s = 44'(ma[20:0]) * 44'(ma[20:0]) + 44'(mb[20:0]) * 44'(mb[20:0])
      + 44'(mc[20:0]) * 44'(mc[20:0]);
    e2 = 44'(eps) * 44'(eps);
    return near && (s <= e2);
  endfunction

endpackage

// ----- rtl/core/lab_dly.sv -----
// ----------------------------------------------------------------------------
// lab_dly: aligning delay line
// Holds side data for a fixed number of pipeline steps, advancing on enable.
// ----------------------------------------------------------------------------
module lab_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // Advance the line
  always_ff @(posedge clk) begin
    if (en_i) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

// ----- rtl/core/lab_norm.sv -----
// ----------------------------------------------------------------------------
// lab_norm: pipelined vector normalize
// Scales a 3-vector so its largest component sits in [2^30, 2^31), takes an
// integer root of the squared length one bit per stage, then divides each
// component by it one quotient bit per stage. Output is Q1.30.
// ----------------------------------------------------------------------------
module lab_norm (
  input  logic                                clk,
  input  logic                                en_i,
  input  logic signed [lab_pkg::VEC_W-1:0]    vec_i [3],
  output logic signed [31:0]                  vec_o [3]
);

  localparam int SQ = lab_pkg::SQRT_STG;
  localparam int DV = lab_pkg::DIV_STG;

  // Position of the leading one
  function automatic logic [5:0] lead_fn(input logic [39:0] x);
    logic [5:0] p;
    p = '0;
    for (int b = 0; b < 40; b++) begin
      if (x[b]) p = 6'(b);
    end
    return p;
  endfunction

  logic [39:0] mag1_r [3];
  logic        neg1_r [3];
  logic [39:0] mx1_r;
  logic [39:0] mg    [3];
  logic [39:0] mx;

  // Take magnitudes and the largest one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = 40'(lab_pkg::mag_fn(vec_i[i]));
    end
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mg[i];
        neg1_r[i] <= vec_i[i][lab_pkg::VEC_W-1];
      end
      mx1_r <= mx;
    end
  end

  // Find the leading one
  logic [39:0] mag2_r [3];
  logic        neg2_r [3];
  logic [5:0]  pos2_r;
  logic        zero2_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      pos2_r  <= lead_fn(mx1_r);
      zero2_r <= (mx1_r == '0);
    end
  end

  // Shift into range
  logic [30:0] sh3_r [3];
  logic        neg3_r [3];
  logic        zero3_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (pos2_r >= 6'd30) begin
          sh3_r[i] <= 31'(mag2_r[i] >> 6'(pos2_r - 6'd30));
        end else begin
          sh3_r[i] <= 31'(mag2_r[i] << 6'(6'd30 - pos2_r));
        end
      end
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  // Square components
  logic [61:0] sq4_r [3];
  logic [30:0] sh4_r [3];
  logic        neg4_r [3];
  logic        zero4_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= 62'(sh3_r[i]) * 62'(sh3_r[i]);
      end
      sh4_r   <= sh3_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  // Root pipeline: entry 0 holds the summed squares
  logic [65:0] rem_r  [SQ+1];
  logic [31:0] root_r [SQ+1];
  logic [30:0] shs_r  [SQ+1][3];
  logic        negs_r [SQ+1][3];
  logic        zros_r [SQ+1];

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0]  <= 66'(sq4_r[0]) + 66'(sq4_r[1]) + 66'(sq4_r[2]);
      root_r[0] <= '0;
      shs_r[0]  <= sh4_r;
      negs_r[0] <= neg4_r;
      zros_r[0] <= zero4_r;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int K = SQ - 1 - j;
    logic [65:0] trial;
    assign trial = (66'(root_r[j]) << (K + 1)) + (66'd1 << (2 * K));
    // Decide one root bit
    always_ff @(posedge clk) begin
      if (en_i) begin
        if (rem_r[j] >= trial) begin
          rem_r[j+1]  <= rem_r[j] - trial;
          root_r[j+1] <= root_r[j] | (32'd1 << K);
        end else begin
          rem_r[j+1]  <= rem_r[j];
          root_r[j+1] <= root_r[j];
        end
        shs_r[j+1]  <= shs_r[j];
        negs_r[j+1] <= negs_r[j];
        zros_r[j+1] <= zros_r[j];
      end
    end
  end

  // Divider pipeline: entry 0 holds the rounded numerators
  logic [62:0] num_r  [DV+1][3];
  logic [30:0] quo_r  [DV+1][3];
  logic [31:0] len_r  [DV+1];
  logic        negd_r [DV+1][3];
  logic        zrod_r [DV+1];

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num_r[0][i] <= (63'(shs_r[SQ][i]) << 30) + 63'(root_r[SQ] >> 1);
        quo_r[0][i] <= '0;
      end
      len_r[0]  <= root_r[SQ];
      negd_r[0] <= negs_r[SQ];
      zrod_r[0] <= zros_r[SQ];
    end
  end

  for (genvar j = 0; j < DV; j++) begin : g_div
    localparam int K = DV - 1 - j;
    logic [62:0] dsub;
    assign dsub = 63'(len_r[j]) << K;
    // Decide one quotient bit per component
    always_ff @(posedge clk) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (num_r[j][i] >= dsub) begin
            num_r[j+1][i] <= num_r[j][i] - dsub;
            quo_r[j+1][i] <= quo_r[j][i] | (31'd1 << K);
          end else begin
            num_r[j+1][i] <= num_r[j][i];
            quo_r[j+1][i] <= quo_r[j][i];
          end
        end
        len_r[j+1]  <= len_r[j];
        negd_r[j+1] <= negd_r[j];
        zrod_r[j+1] <= zrod_r[j];
      end
    end
  end

  // Restore signs; zero vector stays zero
  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (zrod_r[DV]) begin
          vec_o[i] <= '0;
        end else if (negd_r[DV][i]) begin
          vec_o[i] <= -$signed(32'(quo_r[DV][i]));
        end else begin
          vec_o[i] <= $signed(32'(quo_r[DV][i]));
        end
      end
    end
  end

endmodule

// ----- rtl/core/look_at_basis_core.sv -----
// Throughput: one item per cycle while the output is not stalled; each
// normalize unit is a 70-stage pipeline with one root bit and one
// quotient bit resolved per stage.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and sets
// input_epsilon to 0 and unit_epsilon to 128.
// ----------------------------------------------------------------------------
// look_at_basis_core: camera basis from eye, target and up hint
// Builds forward, up and right axes in Q1.30 and passes the eye through.
// ----------------------------------------------------------------------------
module look_at_basis_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lab_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lab_pkg::UNIT_EPS_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_x, hint_y, hint_z
  input  logic [287:0]                     in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // right_x, right_y, right_z, fwd_x, fwd_y, fwd_z,
  // upaxis_x, upaxis_y, upaxis_z, origin_x, origin_y, origin_z
  output logic [383:0]                     out_tdata
);

  localparam int NL  = lab_pkg::NORM_LAT;
  localparam int TOT = 12 + 2 * NL;
  localparam logic signed [31:0] ONE32 = 32'sd1073741824;
  localparam logic signed [33:0] ONE34 = 34'sd1073741824;

  logic en;
  logic [TOT:1] vld_r;

  assign en         = out_tready | ~out_tvalid;
  assign in_tready  = en;
  assign out_tvalid = vld_r[TOT];

  // Configuration registers
  logic [lab_pkg::IN_EPS_W-1:0]   in_eps_r;
  logic [lab_pkg::UNIT_EPS_W-1:0] unit_eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_eps_r   <= '0;
      unit_eps_r <= lab_pkg::UNIT_EPS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lab_pkg::CFG_INPUT_EPS: in_eps_r   <= cfg_wdata[lab_pkg::IN_EPS_W-1:0];
        lab_pkg::CFG_UNIT_EPS:  unit_eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-1:1], in_tvalid};
    end
  end

  // Capture the input transfer
  logic signed [31:0] eye1_r [3];
  logic signed [31:0] tgt1_r [3];
  logic signed [31:0] hnt1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye1_r[i] <= in_tdata[32*i +: 32];
        tgt1_r[i] <= in_tdata[96 + 32*i +: 32];
        hnt1_r[i] <= in_tdata[192 + 32*i +: 32];
      end
    end
  end

  // Eye-to-target difference
  logic signed [lab_pkg::VEC_W-1:0] d2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d2_r[i] <= lab_pkg::VEC_W'(tgt1_r[i]) - lab_pkg::VEC_W'(eye1_r[i]);
      end
    end
  end

  // Degenerate test on the difference
  logic degd3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      degd3_r <= lab_pkg::deg_fn(d2_r[0], d2_r[1], d2_r[2],
                                 lab_pkg::UNIT_EPS_W'(in_eps_r));
    end
  end

  logic signed [31:0] nf_o [3];

  lab_norm u_norm_fwd (
    .clk   (clk),
    .en_i  (en),
    .vec_i (d2_r),
    .vec_o (nf_o)
  );

  logic degd_n;

  lab_dly #(.WIDTH(1), .DEPTH(NL - 1)) u_dly_degd (
    .clk  (clk),
    .en_i (en),
    .d_i  (degd3_r),
    .q_o  (degd_n)
  );

  logic [191:0] eh_in;
  logic [191:0] eh_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eh_in[32*i +: 32]      = eye1_r[i];
      eh_in[96 + 32*i +: 32] = hnt1_r[i];
    end
  end

  lab_dly #(.WIDTH(192), .DEPTH(NL + 1)) u_dly_eh (
    .clk  (clk),
    .en_i (en),
    .d_i  (eh_in),
    .q_o  (eh_n)
  );

  // Forward axis stage and its carried context
  logic signed [31:0] fp_r  [1:8][3];
  logic signed [31:0] ep_r  [1:8][3];
  logic signed [31:0] hp_r  [1:5][3];
  logic signed [33:0] uzp_r [3:7][3];
  logic signed [33:0] uyp_r [3:7][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (degd_n) begin
          fp_r[1][i] <= (i == 1) ? ONE32 : '0;
        end else begin
          fp_r[1][i] <= nf_o[i];
        end
        ep_r[1][i] <= eh_n[32*i +: 32];
        hp_r[1][i] <= eh_n[96 + 32*i +: 32];
      end
      for (int k = 2; k <= 8; k++) begin
        fp_r[k] <= fp_r[k-1];
        ep_r[k] <= ep_r[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        hp_r[k] <= hp_r[k-1];
      end
      for (int k = 4; k <= 7; k++) begin
        uzp_r[k] <= uzp_r[k-1];
        uyp_r[k] <= uyp_r[k-1];
      end
    end
  end

  // Hint-forward products and fallback products
  logic signed [63:0] pd_r [3];
  logic signed [63:0] pz_r [3];
  logic signed [63:0] py_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i] <= 64'(hp_r[1][i]) * 64'(fp_r[1][i]);
        pz_r[i] <= 64'(fp_r[1][i]) * 64'(fp_r[1][2]);
        py_r[i] <= 64'(fp_r[1][i]) * 64'(fp_r[1][1]);
      end
    end
  end

  // Dot sum and fallback up candidates
  logic signed [65:0] dot3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dot3_r <= 66'(pd_r[0]) + 66'(pd_r[1]) + 66'(pd_r[2]);
      for (int i = 0; i < 3; i++) begin
        uzp_r[3][i] <= ((i == 2) ? ONE34 : 34'sd0)
                       - 34'(lab_pkg::rnd30_fn(66'(pz_r[i])));
        uyp_r[3][i] <= ((i == 1) ? ONE34 : 34'sd0)
                       - 34'(lab_pkg::rnd30_fn(66'(py_r[i])));
      end
    end
  end

  // Clamped projection length
  logic signed [35:0] dqr;
  logic signed [17:0] dq4_r;

  assign dqr = lab_pkg::rnd30_fn(dot3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (dqr > 36'sd65536) begin
        dq4_r <= 18'sd65536;
      end else if (dqr < -36'sd65536) begin
        dq4_r <= -18'sd65536;
      end else begin
        dq4_r <= 18'(dqr);
      end
    end
  end

  // Projection vector
  logic signed [49:0] q5_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q5_r[i] <= 50'(fp_r[4][i]) * 50'(dq4_r);
      end
    end
  end

  // Remove the projection from the hint
  logic signed [33:0] u6_r [3];
  logic signed [33:0] u7_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u6_r[i] <= 34'(hp_r[5][i]) - 34'(lab_pkg::rnd30_fn(66'(q5_r[i])));
      end
      u7_r <= u6_r;
    end
  end

  // Degenerate tests on all up candidates
  logic dgu7_r;
  logic dgz7_r;
  logic dgy7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dgu7_r <= lab_pkg::deg_fn(42'(u6_r[0]), 42'(u6_r[1]), 42'(u6_r[2]),
                                lab_pkg::UNIT_EPS_W'(in_eps_r));
      dgz7_r <= lab_pkg::deg_fn(42'(uzp_r[6][0]), 42'(uzp_r[6][1]),
                                42'(uzp_r[6][2]), unit_eps_r);
      dgy7_r <= lab_pkg::deg_fn(42'(uyp_r[6][0]), 42'(uyp_r[6][1]),
                                42'(uyp_r[6][2]), unit_eps_r);
    end
  end

  // Pick the up candidate
  logic signed [lab_pkg::VEC_W-1:0] us8_r [3];
  logic                             ok8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ok8_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (!dgu7_r) begin
          us8_r[i] <= lab_pkg::VEC_W'(u7_r[i]);
        end else if (!dgz7_r) begin
          us8_r[i] <= lab_pkg::VEC_W'(uzp_r[7][i]);
        end else begin
          us8_r[i] <= lab_pkg::VEC_W'(uyp_r[7][i]);
        end
      end
      if (dgu7_r && dgz7_r && dgy7_r) begin
        ok8_r <= 1'b0;
      end
    end
  end

  logic signed [31:0] nu_o [3];

  lab_norm u_norm_up (
    .clk   (clk),
    .en_i  (en),
    .vec_i (us8_r),
    .vec_o (nu_o)
  );

  logic [192:0] fe_in;
  logic [192:0] fe_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fe_in[32*i +: 32]      = fp_r[8][i];
      fe_in[96 + 32*i +: 32] = ep_r[8][i];
    end
    fe_in[192] = ok8_r;
  end

  lab_dly #(.WIDTH(193), .DEPTH(NL)) u_dly_fe (
    .clk  (clk),
    .en_i (en),
    .d_i  (fe_in),
    .q_o  (fe_n)
  );

  // Cross product terms
  logic signed [31:0] fc_r  [3];
  logic signed [31:0] ec_r  [3];
  logic signed [31:0] uc_r  [3];
  logic               okc_r;
  logic signed [63:0] xa_r  [3];
  logic signed [63:0] xb_r  [3];
  logic signed [31:0] fn    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fn[i] = fe_n[32*i +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fc_r[i] <= fn[i];
        ec_r[i] <= fe_n[96 + 32*i +: 32];
      end
      uc_r  <= nu_o;
      okc_r <= fe_n[192];
      xa_r[0] <= 64'(fn[1]) * 64'(nu_o[2]);
      xb_r[0] <= 64'(fn[2]) * 64'(nu_o[1]);
      xa_r[1] <= 64'(fn[2]) * 64'(nu_o[0]);
      xb_r[1] <= 64'(fn[0]) * 64'(nu_o[2]);
      xa_r[2] <= 64'(fn[0]) * 64'(nu_o[1]);
      xb_r[2] <= 64'(fn[1]) * 64'(nu_o[0]);
    end
  end

  // Output register
  logic signed [31:0] ort_r [3];
  logic signed [31:0] ofw_r [3];
  logic signed [31:0] oup_r [3];
  logic signed [31:0] oor_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (okc_r) begin
          ort_r[i] <= 32'(lab_pkg::rnd30_fn(66'(xa_r[i]) - 66'(xb_r[i])));
          oup_r[i] <= uc_r[i];
        end else begin
          ort_r[i] <= '0;
          oup_r[i] <= '0;
        end
        ofw_r[i] <= fc_r[i];
        oor_r[i] <= ec_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_tdata[32*i +: 32]       = ort_r[i];
      out_tdata[96 + 32*i +: 32]  = ofw_r[i];
      out_tdata[192 + 32*i +: 32] = oup_r[i];
      out_tdata[288 + 32*i +: 32] = oor_r[i];
    end
  end

`ifndef NO_ASSERTIONS
  // A zero up axis always comes with a zero right axis
  a_up_zero_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (oup_r[0] == 0) && (oup_r[1] == 0) && (oup_r[2] == 0)
    |-> (ort_r[0] == 0) && (ort_r[1] == 0) && (ort_r[2] == 0))
    else $error("right axis nonzero with zero up axis");

  // Forward components stay within unit range
  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ofw_r[0] <= ONE32) && (ofw_r[0] >= -ONE32)
                && (ofw_r[1] <= ONE32) && (ofw_r[1] >= -ONE32)
                && (ofw_r[2] <= ONE32) && (ofw_r[2] >= -ONE32))
    else $error("forward component out of range");

  // Every input transfer enters the valid chain
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted item lost at pipeline entry");
`endif

endmodule
